>>> rtl/esf_pkg.sv
// Package: shared types, constants and hash function for the elastic sketch.
`default_nettype none
package esf_pkg;

  localparam int unsigned HeavyBucketsDef  = 1024;
  localparam int unsigned LightCountersDef = 65536;
  localparam int unsigned SlotsPerBucketDef = 8;

  localparam logic [30:0] CountMax  = 31'h7FFF_FFFF;
  localparam logic [7:0]  LightMax  = 8'd255;
  localparam logic [2:0]  RatioRst  = 3'd3;
  localparam logic        KindInsert = 1'b0;
  localparam logic        KindQuery  = 1'b1;
  localparam logic [0:0]  RegRatio   = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [31:0] flow_key;
  } esf_in_t;

  typedef struct packed {
    logic [31:0] frequency;
    logic        light_saturated;
    logic [31:0] saturation_count;
  } esf_out_t;

  // Hash stage selector: mixing is split into short steps, one multiply each.
  typedef enum logic [2:0] {
    HashK1  = 3'd0,
    HashK2  = 3'd1,
    HashH1  = 3'd2,
    HashF1  = 3'd3,
    HashF2  = 3'd4
  } esf_hstep_e;

  function automatic logic [31:0] esf_rotl(input logic [31:0] x, input int unsigned r);
    esf_rotl = (x << r) | (x >> (32 - r));
  endfunction

  // One multiply per step; step selects which part of MurmurHash3 runs.
  function automatic logic [31:0] esf_hash_step(input esf_hstep_e st, input logic [31:0] v,
                                                input logic [31:0] seed);
    logic [31:0] t;
    t = '0;
    unique case (st)
      HashK1: t = v * 32'hcc9e2d51;
      HashK2: t = esf_rotl(v, 15) * 32'h1b873593;
      HashH1: t = (esf_rotl(seed ^ v, 13) * 32'd5 + 32'he6546b64) ^ 32'd4;
      HashF1: t = (v ^ (v >> 16)) * 32'h85ebca6b;
      HashF2: t = (v ^ (v >> 13)) * 32'hc2b2ae35;
      default: t = v;
    endcase
    esf_hash_step = t;
  endfunction

  typedef enum logic [14:0] {
    StIdle   = 15'b000000000000001,
    StHash   = 15'b000000000000010,
    StClear  = 15'b000000000000100,
    StRdLt   = 15'b000000000001000,
    StRdLtW  = 15'b000000000010000,
    StScan   = 15'b000000000100000,
    StScanW  = 15'b000000001000000,
    StVote   = 15'b000000010000000,
    StVoteW  = 15'b000000100000000,
    StDecide = 15'b000001000000000,
    StEvHash = 15'b000010000000000,
    StLtRd   = 15'b000100000000000,
    StLtRdW  = 15'b001000000000000,
    StLtWr   = 15'b010000000000000,
    StDone   = 15'b100000000000000
  } esf_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic       clr_step;    // write zero at clear address, advance
    logic       load;        // capture input beat
    logic       hash_go;     // advance hash engine one step
    logic [1:0] hash_sel;    // 0 heavy key, 1 light key, 2 evicted key
    logic       lt_rd;       // issue light read
    logic       slot_rd;     // issue slot read
    logic       slot_acc;    // fold slot data into scan
    logic       vote_rd;     // issue vote read
    logic       decide;      // apply heavy update
    logic       lt_wr;       // apply light update
    logic       emit;        // drive result beat
  } esf_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hash_done;
    logic slot_last;
    logic hit;          // match found in bucket
    logic need_light;   // insert sends something to light part
    logic evict;        // evicted key needs a light index
  } esf_sts_t;

endpackage
`default_nettype wire

>>> rtl/elastic_sketch_frequency_top.sv
// Top level: elastic sketch flow frequency estimator with APB configuration.
`default_nettype none
// Elastic sketch frequency estimator. Pulse start_i while busy_o is low to
// hand in one beat (insert or query of a 32-bit key); exactly one result beat
// follows on result_o, marked by done_o for one cycle, and it cannot be
// stalled. busy_o stays high while the beat is in work, up to and including
// the result cycle, so no new beat is taken before the last one is through.
// Each item makes two five-step hash runs on one hash engine (light key,
// then heavy key) and a scan of the bucket, one slot read at a time. An
// insert that goes to the light part adds a counter read and write, and an
// eviction adds a third hash run for the evicted key. After reset the block
// clears every heavy, vote and light entry, one address a cycle, with busy_o
// high.
module elastic_sketch_frequency_top #(
  parameter int unsigned HeavyBuckets   = esf_pkg::HeavyBucketsDef,
  parameter int unsigned LightCounters  = esf_pkg::LightCountersDef,
  parameter int unsigned SlotsPerBucket = esf_pkg::SlotsPerBucketDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire esf_pkg::esf_in_t item_i,
  output logic                  busy_o,
  output logic                  done_o,
  output esf_pkg::esf_out_t     result_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [0:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import esf_pkg::*;

  esf_cmd_t cmd;
  esf_sts_t sts;
  logic [2:0] ratio_q;

  // One register at byte address 0; paddr holds bit 2 of the address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioRst;
    end else if (psel && penable && pwrite && paddr == RegRatio) begin
      ratio_q <= pwdata[2:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == RegRatio) ? {29'd0, ratio_q} : 32'd0;

  esf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  esf_datapath #(
    .HeavyBuckets   (HeavyBuckets),
    .LightCounters  (LightCounters),
    .SlotsPerBucket (SlotsPerBucket)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (item_i),
    .ratio_i (ratio_q),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .out_o   (result_o)
  );

  assign done_o = cmd.emit;

endmodule
`default_nettype wire

>>> rtl/esf_datapath.sv
// Datapath: hash engine, heavy/vote/light memories, scan and update logic.
`default_nettype none
module esf_datapath #(
  parameter int unsigned HeavyBuckets  = 1024,
  parameter int unsigned LightCounters = 65536,
  parameter int unsigned SlotsPerBucket = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire esf_pkg::esf_in_t  in_i,
  input  wire logic [2:0]        ratio_i,
  input  wire esf_pkg::esf_cmd_t cmd_i,
  output esf_pkg::esf_sts_t      sts_o,
  output esf_pkg::esf_out_t      out_o
);
  import esf_pkg::*;

  localparam int unsigned Slots  = SlotsPerBucket - 1;
  localparam int unsigned HDepth = HeavyBuckets * Slots;
  localparam int unsigned BW = (HeavyBuckets > 1) ? $clog2(HeavyBuckets) : 1;
  localparam int unsigned LW = (LightCounters > 1) ? $clog2(LightCounters) : 1;
  localparam int unsigned HW = (HDepth > 1) ? $clog2(HDepth) : 1;
  localparam int unsigned SW = $clog2(Slots + 1);
  localparam int unsigned CW = (HW > LW) ? HW : LW;

  logic [31:0] hkey_mem [HDepth];
  logic [31:0] hcnt_mem [HDepth];
  logic [31:0] vote_mem [HeavyBuckets];
  logic [7:0]  lt_mem   [LightCounters];

  logic        kind_q;
  logic [31:0] key_q;
  logic [31:0] hv_q;
  logic [2:0]  hstep_q;
  logic        hash_done_q;
  logic [BW-1:0] bucket_q;
  logic [LW-1:0] lidx_q;
  logic [7:0]  lt_rdat_q, lt_qval_q;
  logic [31:0] key_rdat_q, cnt_rdat_q, vote_rdat_q;
  logic [SW-1:0] slot_q;
  logic        hit_q, empty_fnd_q;
  logic [SW-1:0] hit_slot_q, empty_slot_q, min_slot_q;
  logic [31:0] hit_cnt_q;
  logic [30:0] min_val_q;
  logic [31:0] old_key_q, old_cnt_q;
  logic        evict_q, need_lt_q;
  logic [31:0] lt_amt_q;
  logic        lt_max_q;
  logic        clip_q;
  logic [31:0] ovf_q;
  logic [CW:0] clr_q;

  // Light update value and clip flag.
  logic [8:0] lsum;
  logic [7:0] lt_wdat;
  logic       lt_we, clip_d;

  function automatic logic [HW-1:0] haddr(input logic [BW-1:0] b, input logic [SW-1:0] s);
    logic [HW+SW:0] a;
    a = (HW+SW+1)'(b) * (HW+SW+1)'(Slots) + (HW+SW+1)'(s);
    haddr = a[HW-1:0];
  endfunction

  // Hash engine: five steps, seed picks heavy (1) or light (2).
  logic [31:0] hash_src, hash_next, seed;
  always_comb begin
    seed = (cmd_i.hash_sel == 2'd0) ? 32'd1 : 32'd2;
    hash_src = hv_q;
    if (hstep_q == 3'd0) begin
      hash_src = (cmd_i.hash_sel == 2'd2) ? old_key_q : key_q;
    end
    hash_next = esf_hash_step(esf_hstep_e'(hstep_q), hash_src, seed);
    if (hstep_q == 3'd4) begin
      hash_next = hash_next ^ (hash_next >> 16);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q        <= '0;
      hstep_q     <= '0;
      hash_done_q <= 1'b0;
      ovf_q       <= '0;
      clr_q       <= '0;
    end else begin
      hash_done_q <= 1'b0;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.hash_go && !hash_done_q) begin
        hv_q <= hash_next;
        if (hstep_q == 3'd4) begin
          hstep_q     <= '0;
          hash_done_q <= 1'b1;
        end else begin
          hstep_q <= hstep_q + 3'd1;
        end
      end
      if (cmd_i.lt_wr && clip_d) begin
        if (ovf_q != 32'hFFFF_FFFF) begin
          ovf_q <= ovf_q + 32'd1;
        end
      end
    end
  end

  always_comb begin
    lsum    = {1'b0, lt_rdat_q} + 9'(lt_amt_q[7:0]);
    lt_wdat = lt_rdat_q;
    lt_we   = 1'b0;
    clip_d  = 1'b0;
    if (!lt_max_q) begin
      lt_we = 1'b1;
      if (lt_amt_q > 32'd255 || lsum[8]) begin
        clip_d  = 1'b1;
        lt_wdat = LightMax;
      end else begin
        lt_wdat = lsum[7:0];
      end
    end else if (32'(lt_rdat_q) < lt_amt_q) begin
      lt_we = 1'b1;
      if (lt_amt_q > 32'd255) begin
        clip_d  = 1'b1;
        lt_wdat = LightMax;
      end else begin
        lt_wdat = lt_amt_q[7:0];
      end
    end
  end

  // Eviction test: vote+1 > min << ratio, exact in 40 bits.
  logic [39:0] vote_inc, min_sh;
  logic        ev_d;
  always_comb begin
    vote_inc = 40'(vote_rdat_q) + 40'd1;
    min_sh   = 40'(min_val_q) << ratio_i;
    ev_d     = vote_inc > min_sh;
  end

  // Memories: one access each per cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      if (clr_q < (CW+1)'(HDepth)) begin
        hkey_mem[clr_q[HW-1:0]] <= '0;
        hcnt_mem[clr_q[HW-1:0]] <= '0;
      end
      if (clr_q < (CW+1)'(HeavyBuckets)) vote_mem[clr_q[BW-1:0]] <= '0;
      if (clr_q < (CW+1)'(LightCounters)) lt_mem[clr_q[LW-1:0]] <= '0;
    end
    if (cmd_i.lt_rd) lt_rdat_q <= lt_mem[lidx_q];
    if (cmd_i.lt_wr && lt_we) lt_mem[lidx_q] <= lt_wdat;
    if (cmd_i.slot_rd) begin
      key_rdat_q <= hkey_mem[haddr(bucket_q, slot_q)];
      cnt_rdat_q <= hcnt_mem[haddr(bucket_q, slot_q)];
    end
    if (cmd_i.vote_rd) vote_rdat_q <= vote_mem[bucket_q];
    if (cmd_i.decide && kind_q == KindInsert) begin
      if (hit_q) begin
        if (hit_cnt_q[30:0] != CountMax) hcnt_mem[haddr(bucket_q, hit_slot_q)] <= hit_cnt_q + 32'd1;
      end else if (empty_fnd_q) begin
        hkey_mem[haddr(bucket_q, empty_slot_q)] <= key_q;
        hcnt_mem[haddr(bucket_q, empty_slot_q)] <= 32'd1;
      end else if (ev_d) begin
        vote_mem[bucket_q] <= '0;
        hkey_mem[haddr(bucket_q, min_slot_q)] <= key_q;
        hcnt_mem[haddr(bucket_q, min_slot_q)] <= 32'h8000_0001;
      end else if (vote_rdat_q != 32'hFFFF_FFFF) begin
        vote_mem[bucket_q] <= vote_rdat_q + 32'd1;
      end
    end
  end

  // Scan and control registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_i.kind;
      key_q  <= in_i.flow_key;
      clip_q <= 1'b0;
    end
    if (hash_done_q) begin
      if (cmd_i.hash_sel == 2'd0) bucket_q <= BW'(hv_q % HeavyBuckets);
      else                        lidx_q   <= LW'(hv_q % LightCounters);
      slot_q      <= '0;
      hit_q       <= 1'b0;
      empty_fnd_q <= 1'b0;
      min_slot_q  <= '0;
      min_val_q   <= CountMax;
    end
    if (cmd_i.lt_rd && cmd_i.hash_sel == 2'd1) begin
      slot_q <= '0;
    end
    if (cmd_i.slot_rd) slot_q <= slot_q + 1'b1;
    if (cmd_i.slot_acc && !hit_q) begin
      if (key_rdat_q == key_q) begin
        hit_q      <= 1'b1;
        hit_slot_q <= slot_q - 1'b1;
        hit_cnt_q  <= cnt_rdat_q;
      end else begin
        if (key_rdat_q == '0 && !empty_fnd_q) begin
          empty_fnd_q  <= 1'b1;
          empty_slot_q <= slot_q - 1'b1;
        end
        if (slot_q == SW'(1) || cnt_rdat_q[30:0] < min_val_q) begin
          min_val_q  <= cnt_rdat_q[30:0];
          min_slot_q <= slot_q - 1'b1;
          old_key_q  <= key_rdat_q;
          old_cnt_q  <= cnt_rdat_q;
        end
      end
    end
    if (cmd_i.decide) begin
      evict_q   <= kind_q == KindInsert && !hit_q && !empty_fnd_q && ev_d;
      need_lt_q <= kind_q == KindInsert && !hit_q && !empty_fnd_q;
      lt_max_q  <= ev_d && old_cnt_q[31];
      lt_amt_q  <= ev_d ? {1'b0, old_cnt_q[30:0]} : 32'd1;
      lt_qval_q <= lt_rdat_q;
    end
    if (cmd_i.lt_wr) clip_q <= clip_d;
  end

  logic [31:0] qfreq;
  always_comb begin
    if (hit_q) begin
      qfreq = hit_cnt_q[31] ? {1'b0, hit_cnt_q[30:0]} + 32'(lt_qval_q)
                            : {1'b0, hit_cnt_q[30:0]};
    end else begin
      qfreq = 32'(lt_qval_q);
    end
  end

  assign sts_o.clr_done   = clr_q >= (CW+1)'(HDepth) && clr_q >= (CW+1)'(LightCounters)
                            && clr_q >= (CW+1)'(HeavyBuckets);
  assign sts_o.hash_done  = hash_done_q;
  assign sts_o.slot_last  = slot_q == SW'(Slots);
  assign sts_o.hit        = hit_q;
  assign sts_o.need_light = need_lt_q;
  assign sts_o.evict      = evict_q;

  assign out_o.frequency        = (kind_q == KindQuery) ? qfreq : 32'd0;
  assign out_o.light_saturated  = clip_q;
  assign out_o.saturation_count = ovf_q;

endmodule
`default_nettype wire

>>> rtl/esf_ctrl.sv
// Controller: sequences clear, hash, scan, heavy update and light update.
`default_nettype none
module esf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire esf_pkg::esf_sts_t sts_i,
  output logic                   busy_o,
  output esf_pkg::esf_cmd_t      cmd_o
);
  import esf_pkg::*;

  esf_state_e state_q, state_d;
  logic [1:0] sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      sel_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.hash_sel = sel_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          sel_d      = 2'd1;
          state_d    = StHash;
        end
      end
      StHash: begin
        cmd_o.hash_go = 1'b1;
        if (sts_i.hash_done) begin
          cmd_o.hash_go = 1'b0;
          unique case (sel_q)
            2'd1: begin
              sel_d   = 2'd0;
              state_d = StRdLt;
            end
            2'd0:    state_d = StScan;
            default: state_d = StLtRd;
          endcase
        end
      end
      StRdLt: begin
        cmd_o.lt_rd = 1'b1;
        state_d     = StRdLtW;
      end
      StRdLtW: state_d = StHash;
      StScan: begin
        cmd_o.slot_rd = 1'b1;
        state_d       = StScanW;
      end
      StScanW: begin
        cmd_o.slot_acc = 1'b1;
        state_d = sts_i.slot_last ? StVote : StScan;
      end
      StVote: begin
        cmd_o.vote_rd = 1'b1;
        state_d       = StVoteW;
      end
      StVoteW: state_d = StDecide;
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = StEvHash;
      end
      StEvHash: begin
        if (!sts_i.need_light) begin
          state_d = StDone;
        end else if (sts_i.evict) begin
          sel_d   = 2'd2;
          state_d = StHash;
        end else begin
          state_d = StLtRd;
        end
      end
      StLtRd: begin
        cmd_o.lt_rd = 1'b1;
        state_d     = StLtRdW;
      end
      StLtRdW: state_d = StLtWr;
      StLtWr: begin
        cmd_o.lt_wr = 1'b1;
        state_d     = StDone;
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d    = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = state_q != StIdle;

endmodule
`default_nettype wire

>>> rtl/esf_checker.sv
// Checker: port-level properties of the elastic sketch top level.
`default_nettype none
module esf_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             done_o,
  input wire esf_pkg::esf_out_t result_o
);
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result beat while idle");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat repeated");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("beat taken but not busy");
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("block still busy after result");
  a_sat_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.light_saturated && $past(result_o.saturation_count, 1) != 32'hFFFF_FFFF
    |-> result_o.saturation_count != 32'd0) else $error("saturation count lost");
endmodule

bind elastic_sketch_frequency_top esf_checker u_esf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire
